// File: design/four_city_tour_cost_evaluator_assert.svh
// Assertion macros for the four-city tour cost evaluator.
// Included by the top level; depends on nothing else.
`ifndef FOUR_CITY_TOUR_COST_EVALUATOR_ASSERT_SVH
`define FOUR_CITY_TOUR_COST_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCTCE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fctce: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FCTCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fctce: next-cycle check failed");

`endif

// File: design/fctce_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the cost lane lookup for the tour evaluator.
// No dependencies.
package fctce_pkg;

    localparam int COST_BITS  = 16;
    localparam int LANE_BITS  = 16;
    localparam int NUM_CITIES = 4;
    localparam int CITY_W     = 2;
    localparam int SUM_W      = 18;
    localparam int BEST_W     = 10;
    localparam int CODE_W     = 6;
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 5;

    localparam logic [BEST_W-1:0] BEST_RESET = BEST_W'(1000);

    typedef logic [CITY_W-1:0]    t_city;
    typedef logic [COST_BITS-1:0] t_cost;
    typedef logic [SUM_W-1:0]     t_sum;
    typedef logic [BEST_W-1:0]    t_best;
    typedef logic [DATA_W-1:0]    t_row;
    typedef logic [CODE_W-1:0]    t_code;

    typedef enum logic [CITY_W-1:0] {
        REG_ROW0 = 2'd0,
        REG_ROW1 = 2'd1,
        REG_ROW2 = 2'd2,
        REG_ROW3 = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_sum  objective;
        logic  tour_valid;
        logic  within_bounds;
        logic  improved;
        t_best cost;
        t_city second_city;
        t_city third_city;
        t_city fourth_city;
    } t_score;

    function automatic t_cost lane_cost(t_row row, t_city to);
        return row[LANE_BITS*int'(to) +: COST_BITS];
    endfunction

endpackage

// File: design/fctce_in_if.sv
`timescale 1ns / 1ps
// Request channel carrying one tour code.
// Depends on fctce_pkg.
interface fctce_in_if;
    logic              valid;
    logic              ready;
    fctce_pkg::t_code  tour_code;

    modport source (output valid, output tour_code, input ready);
    modport sink   (input valid, input tour_code, output ready);
endinterface

// File: design/fctce_out_if.sv
`timescale 1ns / 1ps
// Result channel carrying the score of one tour and the kept best.
// Depends on fctce_pkg.
interface fctce_out_if;
    logic             valid;
    logic             ready;
    fctce_pkg::t_sum  objective_value;
    logic             tour_valid;
    logic             within_bounds;
    logic             improved;
    fctce_pkg::t_best best_cost_out;
    fctce_pkg::t_city best_second_city;
    fctce_pkg::t_city best_third_city;
    fctce_pkg::t_city best_fourth_city;

    modport source (output valid, output objective_value, output tour_valid,
                    output within_bounds, output improved, output best_cost_out,
                    output best_second_city, output best_third_city,
                    output best_fourth_city, input ready);
    modport sink   (input valid, input objective_value, input tour_valid,
                    input within_bounds, input improved, input best_cost_out,
                    input best_second_city, input best_third_city,
                    input best_fourth_city, output ready);
endinterface

// File: design/fctce_bounds.sv
`timescale 1ns / 1ps
// Lower and upper cost bounds: row minima and maxima registered as a row is written,
// then summed into registered bounds. Depends on fctce_pkg.
module fctce_bounds (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  fctce_pkg::t_city  i_wr_idx,
    input  fctce_pkg::t_row   i_wr_data,
    output fctce_pkg::t_sum   o_lower,
    output fctce_pkg::t_sum   o_upper
);

    fctce_pkg::t_cost r_min [fctce_pkg::NUM_CITIES];
    fctce_pkg::t_cost r_max [fctce_pkg::NUM_CITIES];
    fctce_pkg::t_sum  r_lower;
    fctce_pkg::t_sum  r_upper;
    fctce_pkg::t_cost w_min;
    fctce_pkg::t_cost w_max;
    fctce_pkg::t_sum  n_lower;
    fctce_pkg::t_sum  n_upper;

    always_comb begin
        fctce_pkg::t_cost v;
        w_min = fctce_pkg::lane_cost(i_wr_data, fctce_pkg::CITY_W'(0));
        w_max = w_min;
        for (int j = 1; j < fctce_pkg::NUM_CITIES; j++) begin
            v = fctce_pkg::lane_cost(i_wr_data, fctce_pkg::CITY_W'(j));
            if (v < w_min) begin
                w_min = v;
            end
            if (v > w_max) begin
                w_max = v;
            end
        end
    end

    always_comb begin
        n_lower = '0;
        n_upper = '0;
        for (int r = 0; r < fctce_pkg::NUM_CITIES; r++) begin
            n_lower = n_lower + fctce_pkg::SUM_W'(r_min[r]);
            n_upper = n_upper + fctce_pkg::SUM_W'(r_max[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < fctce_pkg::NUM_CITIES; r++) begin
                r_min[r] <= '0;
                r_max[r] <= '0;
            end
            r_lower <= '0;
            r_upper <= '0;
        end else begin
            for (int r = 0; r < fctce_pkg::NUM_CITIES; r++) begin
                if (i_wr_en && i_wr_idx == fctce_pkg::CITY_W'(r)) begin
                    r_min[r] <= w_min;
                    r_max[r] <= w_max;
                end
            end
            r_lower <= n_lower;
            r_upper <= n_upper;
        end
    end

    assign o_lower = r_lower;
    assign o_upper = r_upper;

endmodule

// File: design/fctce_score.sv
`timescale 1ns / 1ps
// Scores one tour code: repeat check, tour cost, bound test and best compare.
// Depends on fctce_pkg.
module fctce_score (
    input  fctce_pkg::t_row   i_rows [fctce_pkg::NUM_CITIES],
    input  fctce_pkg::t_code  i_code,
    input  fctce_pkg::t_sum   i_lower,
    input  fctce_pkg::t_sum   i_upper,
    input  fctce_pkg::t_best  i_best_cost,
    output fctce_pkg::t_score o_score
);

    fctce_pkg::t_city w_a;
    fctce_pkg::t_city w_b;
    fctce_pkg::t_city w_c;
    fctce_pkg::t_city w_succ [fctce_pkg::NUM_CITIES];
    fctce_pkg::t_sum  w_cost;
    logic             w_valid;
    logic             w_within;

    assign w_a = i_code[5:4];
    assign w_b = i_code[3:2];
    assign w_c = i_code[1:0];

    // A tour is complete only when the three visited cities are 1, 2 and 3 in some order.
    assign w_valid = (w_a != '0) && (w_b != '0) && (w_c != '0)
                  && (w_a != w_b) && (w_a != w_c) && (w_b != w_c);

    // Each row contributes the edge to its successor on the closed tour.
    always_comb begin
        w_succ[0] = w_a;
        for (int r = 1; r < fctce_pkg::NUM_CITIES; r++) begin
            if (w_a == fctce_pkg::CITY_W'(r)) begin
                w_succ[r] = w_b;
            end else if (w_b == fctce_pkg::CITY_W'(r)) begin
                w_succ[r] = w_c;
            end else begin
                w_succ[r] = '0;
            end
        end
        w_cost = '0;
        for (int r = 0; r < fctce_pkg::NUM_CITIES; r++) begin
            w_cost = w_cost + fctce_pkg::SUM_W'(fctce_pkg::lane_cost(i_rows[r], w_succ[r]));
        end
    end

    assign w_within = w_valid && (w_cost < i_upper) && (w_cost > i_lower);

    assign o_score.objective     = w_within ? w_cost : i_upper;
    assign o_score.tour_valid    = w_valid;
    assign o_score.within_bounds = w_within;
    assign o_score.improved      = w_within && (w_cost < fctce_pkg::SUM_W'(i_best_cost));
    assign o_score.cost          = w_cost[fctce_pkg::BEST_W-1:0];
    assign o_score.second_city   = w_a;
    assign o_score.third_city    = w_b;
    assign o_score.fourth_city   = w_c;

endmodule

// File: design/four_city_tour_cost_evaluator.sv
`timescale 1ns / 1ps
// Top level of the four-city tour cost evaluator: config registers, pipeline, kept best.
// Depends on fctce_pkg, fctce_in_if, fctce_out_if, fctce_bounds, fctce_score.
//
//   Channel   Direction  Contents
//   i_req     in         tour_code (6 bits), valid/ready
//   o_rsp     out        objective_value, flags, kept best cost and path, valid/ready
//   APB       in/out     four 64-bit cost rows at byte addresses 0, 8, 16, 24
//
// A request is taken into an input register and scored from there into the result register;
// one request is taken every cycle while o_rsp.ready is high. The kept best is updated as an
// improving score enters the result register, in order. The result register stalls on
// o_rsp.ready; i_req.ready falls only while both stages are full and o_rsp.ready is low.
// Bounds follow a row write through the registered row minima and maxima, then the summed
// bounds register. Synchronous reset clears rows and bounds and sets the best cost to 1000.
`include "four_city_tour_cost_evaluator_assert.svh"

module four_city_tour_cost_evaluator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fctce_in_if.sink                       i_req,
    fctce_out_if.source                    o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fctce_pkg::ADDR_W-1:0]   paddr,
    input  fctce_pkg::t_row                pwdata,
    output fctce_pkg::t_row                prdata,
    output logic                           pready
);

    fctce_pkg::t_row   r_rows [fctce_pkg::NUM_CITIES];
    logic              r_s1_valid;
    fctce_pkg::t_code  r_s1_code;
    logic              r_out_valid;
    fctce_pkg::t_sum   r_out_objective;
    logic              r_out_tour_valid;
    logic              r_out_within;
    logic              r_out_improved;
    fctce_pkg::t_best  r_best_cost;
    fctce_pkg::t_city  r_best_second;
    fctce_pkg::t_city  r_best_third;
    fctce_pkg::t_city  r_best_fourth;

    fctce_pkg::t_reg_idx w_reg_idx;
    logic              w_wr_en;
    fctce_pkg::t_sum   w_lower;
    fctce_pkg::t_sum   w_upper;
    fctce_pkg::t_score w_score;
    logic              w_out_free;
    logic              w_s1_go;
    logic              w_in_take;

    assign w_reg_idx = fctce_pkg::t_reg_idx'(paddr[fctce_pkg::ADDR_W-1:3]);
    assign w_wr_en   = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb begin
        case (w_reg_idx)
            fctce_pkg::REG_ROW0: prdata = r_rows[0];
            fctce_pkg::REG_ROW1: prdata = r_rows[1];
            fctce_pkg::REG_ROW2: prdata = r_rows[2];
            fctce_pkg::REG_ROW3: prdata = r_rows[3];
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < fctce_pkg::NUM_CITIES; r++) begin
                r_rows[r] <= '0;
            end
        end else if (w_wr_en) begin
            r_rows[w_reg_idx] <= pwdata;
        end
    end

    fctce_bounds u_bounds (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_idx  (paddr[fctce_pkg::ADDR_W-1:3]),
        .i_wr_data (pwdata),
        .o_lower   (w_lower),
        .o_upper   (w_upper)
    );

    fctce_score u_score (
        .i_rows      (r_rows),
        .i_code      (r_s1_code),
        .i_lower     (w_lower),
        .i_upper     (w_upper),
        .i_best_cost (r_best_cost),
        .o_score     (w_score)
    );

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_s1_go     = r_s1_valid && w_out_free;
    assign i_req.ready = !r_s1_valid || w_out_free;
    assign w_in_take   = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_best_cost   <= fctce_pkg::BEST_RESET;
            r_best_second <= '0;
            r_best_third  <= '0;
            r_best_fourth <= '0;
        end else begin
            if (w_in_take) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_s1_go && w_score.improved) begin
                r_best_cost   <= w_score.cost;
                r_best_second <= w_score.second_city;
                r_best_third  <= w_score.third_city;
                r_best_fourth <= w_score.fourth_city;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_code <= i_req.tour_code;
        end
        if (w_s1_go) begin
            r_out_objective  <= w_score.objective;
            r_out_tour_valid <= w_score.tour_valid;
            r_out_within     <= w_score.within_bounds;
            r_out_improved   <= w_score.improved;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.objective_value  = r_out_objective;
    assign o_rsp.tour_valid       = r_out_tour_valid;
    assign o_rsp.within_bounds    = r_out_within;
    assign o_rsp.improved         = r_out_improved;
    assign o_rsp.best_cost_out    = r_best_cost;
    assign o_rsp.best_second_city = r_best_second;
    assign o_rsp.best_third_city  = r_best_third;
    assign o_rsp.best_fourth_city = r_best_fourth;

    `FCTCE_ASSERT_IMPL(a_best_bounded, i_clk, i_rst_n, 1'b1, r_best_cost <= fctce_pkg::BEST_RESET)
    `FCTCE_ASSERT_IMPL(a_improved_in_bounds, i_clk, i_rst_n, r_out_valid && r_out_improved,
        r_out_within && r_out_tour_valid)
    `FCTCE_ASSERT_IMPL(a_improved_best_match, i_clk, i_rst_n, r_out_valid && r_out_improved,
        fctce_pkg::SUM_W'(r_best_cost) == r_out_objective)
    `FCTCE_ASSERT_NEXT(a_best_only_on_improve, i_clk, i_rst_n, !(w_s1_go && w_score.improved),
        $stable(r_best_cost))

endmodule
